// ----- rtl/masked_geometric_mean_top_defines.svh -----
`ifndef MASKED_GEOMETRIC_MEAN_TOP_DEFINES_SVH
`define MASKED_GEOMETRIC_MEAN_TOP_DEFINES_SVH

// Implication checked in the cycle after the antecedent, ignored while reset is held.
`define MGM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mgm check failed");

// Same, but also checked across reset.
`define MGM_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mgm check failed");

`endif

// ----- rtl/mgm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mgm_pkg;

    localparam int MAX_ORDERS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MANT_BITS      = 30;
    localparam int MAG_W          = 32;
    localparam int ORD_W          = 7;
    localparam int EPS_W          = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CMP_W          = 9;

    localparam logic [CFG_IDX_W-1:0] REG_ORDERS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG,
        S_END,
        S_MEAN,
        S_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_NORM,
        A_SQR,
        A_DIV,
        A_FIX,
        A_LOAD,
        A_SQRT,
        A_SCALE
    } t_ar_state;

    typedef struct packed {
        logic start_log;
        logic start_mean;
    } t_ar_cmd;

    typedef struct packed {
        logic log_done;
        logic mean_done;
    } t_ar_sts;

endpackage
`default_nettype wire

// ----- rtl/mgm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mgm_in_if;
    logic                        valid;
    logic                        ready;
    logic [mgm_pkg::MAG_W-1:0]   magnitude;
    logic [mgm_pkg::ORD_W-1:0]   order_count;

    modport source (output valid, output magnitude, output order_count, input ready);
    modport sink   (input valid, input magnitude, input order_count, output ready);
endinterface

interface mgm_out_if;
    logic                        valid;
    logic                        ready;
    logic [mgm_pkg::MAG_W-1:0]   geo_mean;

    modport source (output valid, output geo_mean, input ready);
    modport sink   (input valid, input geo_mean, output ready);
endinterface
`default_nettype wire

// ----- rtl/mgm_arith.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mgm_arith #(
    parameter int MAX_ORDERS = mgm_pkg::MAX_ORDERS_DEF,
    parameter int FRAC_BITS  = mgm_pkg::FRAC_BITS_DEF,
    localparam int LOG_W     = FRAC_BITS + 7,
    localparam int LEN_W     = $clog2(MAX_ORDERS + 1),
    localparam int ACC_W     = LOG_W + LEN_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mgm_pkg::t_ar_cmd           i_cmd,
    input  wire logic [mgm_pkg::MAG_W:0]    i_x,
    input  wire logic signed [ACC_W-1:0]    i_acc,
    input  wire logic [LEN_W-1:0]           i_div,
    output mgm_pkg::t_ar_sts                o_sts,
    output logic signed [LOG_W-1:0]         o_log,
    output logic [mgm_pkg::MAG_W-1:0]       o_geo
);
    import mgm_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + MANT_BITS + 1);
    localparam int BIT_W = $clog2(FRAC_BITS + 1);
    localparam int X_W   = MAG_W + 1;

    t_ar_state r_state, n_state;

    logic [CNT_W-1:0]        r_cnt;
    logic [BIT_W-1:0]        r_bit;
    logic [X_W-1:0]          r_v;
    logic [5:0]              r_lz;
    logic signed [6:0]       r_int;
    logic [MANT_BITS:0]      r_m;
    logic [FRAC_BITS-1:0]    r_frac;
    logic                    r_neg;
    logic [ACC_W-1:0]        r_dvd;
    logic [LEN_W-1:0]        r_dsr;
    logic [LEN_W-1:0]        r_rem;
    logic signed [ACC_W-1:0] r_mean;
    logic [FRAC_BITS-1:0]    r_fsh;
    logic [MANT_BITS:0]      r_y;
    logic [2*MANT_BITS+1:0]  r_op;
    logic [MANT_BITS:0]      r_root;
    logic [MANT_BITS+2:0]    r_srem;
    logic                    r_log_done;
    logic                    r_mean_done;
    logic [MAG_W-1:0]        r_geo;

    // normalising step
    logic [5:0]              norm_sh;
    logic                    norm_zero;
    // squaring step
    logic [2*MANT_BITS+1:0]  sq_p;
    logic [MANT_BITS+1:0]    sq_q;
    // divide step
    logic [LEN_W:0]          div_r2;
    logic                    div_ge;
    logic [ACC_W-1:0]        fix_q1;
    logic signed [ACC_W-1:0] fix_mean;
    // square-root step
    logic [MANT_BITS+4:0]    rt_r2;
    logic [MANT_BITS+2:0]    rt_trial;
    logic                    rt_ge;
    logic [MANT_BITS+1:0]    ld_y;
    // final scaling
    logic signed [ACC_W-1:0] sc_k;
    logic signed [ACC_W:0]   sc_s;
    logic signed [ACC_W:0]   sc_t;
    logic [5:0]              sc_sh;
    logic [63:0]             sc_y;
    logic [63:0]             sc_r;
    logic [MAG_W-1:0]        sc_geo;

    always_comb begin
        norm_sh   = 6'd32 >> r_cnt;
        norm_zero = (r_v >> (6'd33 - norm_sh)) == '0;

        sq_p = {{(MANT_BITS+1){1'b0}}, r_m} * {{(MANT_BITS+1){1'b0}}, r_m};
        sq_q = sq_p[2*MANT_BITS+1:MANT_BITS];

        div_r2 = {r_rem, r_dvd[ACC_W-1]};
        div_ge = div_r2 >= {1'b0, r_dsr};
        fix_q1 = r_dvd + ACC_W'(r_rem != '0);
        fix_mean = r_neg ? -$signed(fix_q1) : $signed(r_dvd);

        rt_r2    = {r_srem, r_op[2*MANT_BITS+1:2*MANT_BITS]};
        rt_trial = {r_root, 2'b01};
        rt_ge    = rt_r2 >= (MANT_BITS+5)'(rt_trial);
        ld_y     = r_fsh[0] ? {r_y, 1'b0} : {1'b0, r_y};

        sc_k  = r_mean >>> FRAC_BITS;
        sc_s  = {sc_k[ACC_W-1], sc_k} + (ACC_W+1)'(FRAC_BITS - MANT_BITS);
        sc_t  = -sc_s;
        sc_y  = {{(64-MANT_BITS-1){1'b0}}, r_y};
        sc_sh = 6'd0;
        sc_r  = '0;
        sc_geo = '0;
        if (!sc_s[ACC_W]) begin
            if (sc_s > (ACC_W+1)'(32)) begin
                sc_geo = '1;
            end else begin
                sc_sh  = 6'(sc_s);
                sc_r   = sc_y << sc_sh;
                sc_geo = (sc_r[63:32] != '0) ? '1 : sc_r[31:0];
            end
        end else if (sc_t < (ACC_W+1)'(63)) begin
            sc_sh  = 6'(sc_t);
            sc_r   = (sc_y + (64'd1 << (sc_sh - 6'd1))) >> sc_sh;
            sc_geo = sc_r[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_cmd.start_log) begin
                    n_state = A_NORM;
                end else if (i_cmd.start_mean) begin
                    n_state = A_DIV;
                end
            end
            A_NORM:  if (r_cnt == CNT_W'(6)) n_state = A_SQR;
            A_SQR:   if (r_cnt == CNT_W'(FRAC_BITS - 1)) n_state = A_IDLE;
            A_DIV:   if (r_cnt == CNT_W'(ACC_W - 1)) n_state = A_FIX;
            A_FIX:   n_state = A_LOAD;
            A_LOAD:  n_state = A_SQRT;
            A_SQRT: begin
                if (r_cnt == CNT_W'(MANT_BITS)) begin
                    n_state = (r_bit == BIT_W'(FRAC_BITS - 1)) ? A_SCALE : A_LOAD;
                end
            end
            A_SCALE: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= A_IDLE;
            r_log_done  <= 1'b0;
            r_mean_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_log_done  <= (r_state == A_SQR) && (n_state == A_IDLE);
            r_mean_done <= (r_state == A_SCALE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= r_cnt + CNT_W'(1);
        case (r_state)
            A_IDLE: begin
                r_cnt <= '0;
                r_v   <= i_x;
                r_lz  <= '0;
                r_neg <= i_acc[ACC_W-1];
                r_dvd <= i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
                r_dsr <= i_div;
                r_rem <= '0;
            end
            A_NORM: begin
                if (r_cnt == CNT_W'(6)) begin
                    r_cnt  <= '0;
                    r_int  <= 7'sd32 - 7'(r_lz) - 7'(FRAC_BITS);
                    r_m    <= r_v[X_W-1:2];
                    r_frac <= '0;
                end else if (norm_zero) begin
                    r_v  <= r_v << norm_sh;
                    r_lz <= r_lz + norm_sh;
                end
            end
            A_SQR: begin
                if (sq_q[MANT_BITS+1]) begin
                    r_m    <= sq_q[MANT_BITS+1:1];
                    r_frac <= {r_frac[FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_m    <= sq_q[MANT_BITS:0];
                    r_frac <= {r_frac[FRAC_BITS-2:0], 1'b0};
                end
            end
            A_DIV: begin
                r_rem <= div_ge ? LEN_W'(div_r2 - {1'b0, r_dsr}) : LEN_W'(div_r2);
                r_dvd <= {r_dvd[ACC_W-2:0], div_ge};
            end
            A_FIX: begin
                r_mean <= fix_mean;
                r_fsh  <= fix_mean[FRAC_BITS-1:0];
                r_y    <= (MANT_BITS+1)'(1) << MANT_BITS;
                r_bit  <= '0;
            end
            A_LOAD: begin
                r_op   <= {ld_y, {MANT_BITS{1'b0}}};
                r_root <= '0;
                r_srem <= '0;
                r_cnt  <= '0;
                r_fsh  <= r_fsh >> 1;
            end
            A_SQRT: begin
                r_op <= r_op << 2;
                if (rt_ge) begin
                    r_srem <= (MANT_BITS+3)'(rt_r2 - (MANT_BITS+5)'(rt_trial));
                    r_root <= {r_root[MANT_BITS-1:0], 1'b1};
                end else begin
                    r_srem <= (MANT_BITS+3)'(rt_r2);
                    r_root <= {r_root[MANT_BITS-1:0], 1'b0};
                end
                if (r_cnt == CNT_W'(MANT_BITS)) begin
                    r_y   <= {r_root[MANT_BITS-1:0], rt_ge};
                    r_bit <= r_bit + BIT_W'(1);
                end
            end
            A_SCALE: r_geo <= sc_geo;
            default: ;
        endcase
    end

    assign o_sts.log_done  = r_log_done;
    assign o_sts.mean_done = r_mean_done;
    assign o_log           = {r_int, r_frac};
    assign o_geo           = r_geo;

endmodule
`default_nettype wire

// ----- rtl/masked_geometric_mean_top.sv -----
// Masked geometric mean over the orders of one column, unsigned fixed point
// with FRAC_BITS fraction bits.
//
// i_in carries one magnitude per beat; order_count is sampled on the first
// beat of a column. A column is orders_per_column beats long (0 reads as 1,
// anything above MAX_ORDERS as MAX_ORDERS). o_out carries one geo_mean beat
// at the end of each column. Configuration goes through i_cfg_we / i_cfg_idx
// / i_cfg_data while idle, a rule for the user that the block does not enforce.
//
// Flow: one input beat at a time. A used, nonzero value runs the normalise
// steps and then the FRAC_BITS-step square-and-compare log2 loop on one
// 31x31 multiplier; an unused or zero value skips the log. The last beat of a
// column adds the mean: a restoring divide over LOG_W + LEN_W quotient bits,
// then FRAC_BITS square roots on the shared root unit; an empty or zero
// column skips the mean.
//
// Reset (synchronous, active low) clears the column position, sum and the
// output valid flag, and sets both registers to 1. A stalled receiver holds
// the result; the block takes further beats until a second result is ready,
// then waits.
`timescale 1ns / 1ps
`default_nettype none
module masked_geometric_mean_top #(
    parameter int MAX_ORDERS = mgm_pkg::MAX_ORDERS_DEF,
    parameter int FRAC_BITS  = mgm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mgm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mgm_pkg::CFG_W-1:0]      i_cfg_data,
    mgm_in_if.sink                              i_in,
    mgm_out_if.source                           o_out
);
    import mgm_pkg::*;

    localparam int LOG_W = FRAC_BITS + 7;
    localparam int LEN_W = $clog2(MAX_ORDERS + 1);
    localparam int ACC_W = LOG_W + LEN_W;

    t_top_state r_state, n_state;

    logic [ORD_W-1:0]        r_opc;
    logic [EPS_W-1:0]        r_eps;
    logic [LEN_W-1:0]        r_pos;
    logic [LEN_W-1:0]        r_lat;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_zero;
    logic                    r_last;
    logic [MAG_W:0]          r_x;
    logic [MAG_W-1:0]        r_res;
    logic                    r_out_valid;
    logic [MAG_W-1:0]        r_out_data;

    t_ar_cmd                 ar_cmd;
    t_ar_sts                 ar_sts;
    logic signed [LOG_W-1:0] ar_log;
    logic [MAG_W-1:0]        ar_geo;

    logic                    in_acc;
    logic                    out_load;
    logic [CMP_W-1:0]        len9;
    logic [CMP_W-1:0]        oc9;
    logic [CMP_W-1:0]        pos9;
    logic [CMP_W-1:0]        lat9;
    logic [MAG_W:0]          x_now;
    logic                    used;
    logic                    need_log;

    always_comb begin
        len9 = (r_opc == '0) ? CMP_W'(1) : CMP_W'(r_opc);
        if (len9 > CMP_W'(MAX_ORDERS)) begin
            len9 = CMP_W'(MAX_ORDERS);
        end
        oc9  = CMP_W'(i_in.order_count);
        pos9 = CMP_W'(r_pos);
        if (r_pos == '0) begin
            lat9 = (oc9 > len9) ? len9 : oc9;
        end else begin
            lat9 = CMP_W'(r_lat);
        end
        x_now    = {1'b0, i_in.magnitude} + (MAG_W+1)'(r_eps);
        used     = pos9 < lat9;
        need_log = used && (x_now != '0);
        in_acc   = i_in.valid && i_in.ready;
        out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = need_log ? S_LOG : S_END;
                end
            end
            S_LOG: if (ar_sts.log_done) n_state = S_END;
            S_END: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if ((r_lat == '0) || r_zero) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: if (ar_sts.mean_done) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready        = (r_state == S_IDLE);
        ar_cmd.start_log  = (r_state == S_IDLE) && in_acc && need_log;
        ar_cmd.start_mean = (r_state == S_END) && r_last && (r_lat != '0) && !r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_opc       <= ORD_W'(1);
            r_eps       <= EPS_W'(1);
            r_pos       <= '0;
            r_lat       <= '0;
            r_acc       <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ORDERS:  r_opc <= i_cfg_data[ORD_W-1:0];
                    REG_EPSILON: r_eps <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_lat  <= LEN_W'(lat9);
                r_last <= (pos9 + CMP_W'(1)) >= len9;
                if (r_pos == '0) begin
                    r_acc  <= '0;
                    r_zero <= used && (x_now == '0);
                end else if (used && (x_now == '0)) begin
                    r_zero <= 1'b1;
                end
            end
            if ((r_state == S_LOG) && ar_sts.log_done) begin
                r_acc <= r_acc + {{(ACC_W-LOG_W){ar_log[LOG_W-1]}}, ar_log};
            end
            if (r_state == S_END) begin
                if (r_last) begin
                    // column complete: drop state, sum already handed over
                    r_pos  <= '0;
                    r_lat  <= '0;
                    r_acc  <= '0;
                    r_zero <= 1'b0;
                    r_res  <= (r_lat == '0) ? MAG_W'(1) << FRAC_BITS : '0;
                end else begin
                    r_pos <= r_pos + LEN_W'(1);
                end
            end
            if ((r_state == S_MEAN) && ar_sts.mean_done) begin
                r_res <= ar_geo;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= x_now;
        end
    end

    mgm_arith #(
        .MAX_ORDERS (MAX_ORDERS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ar_cmd),
        .i_x     ((r_state == S_IDLE) ? x_now : r_x),
        .i_acc   (r_acc),
        .i_div   (r_lat),
        .o_sts   (ar_sts),
        .o_log   (ar_log),
        .o_geo   (ar_geo)
    );

    assign o_out.valid    = r_out_valid;
    assign o_out.geo_mean = r_out_data;

endmodule
`default_nettype wire

// ----- rtl/mgm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "masked_geometric_mean_top_defines.svh"
module mgm_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [mgm_pkg::MAG_W-1:0] i_out_data
);
    logic in_beat;
    logic out_stall;

    assign in_beat   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    `MGM_ASSERT_NEXT(a_out_hold, out_stall, i_out_valid)
    `MGM_ASSERT_NEXT(a_out_data_hold, out_stall, $stable(i_out_data))
    `MGM_ASSERT_NEXT(a_busy_after_beat, in_beat, !i_in_ready)
    `MGM_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !i_rst_n, !i_out_valid)

endmodule

bind masked_geometric_mean_top mgm_checker u_mgm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.geo_mean)
);
`default_nettype wire
